@@ src/pls_pkg.sv @@
// Shared types and constants for the Phong light shader.
package pls_pkg;

	localparam int ONE_Q14   = 16384;
	localparam int FRAC_W    = 14;
	localparam int COL_SHIFT = 26;

	// Vector entering a normalizer: reflection needs 21 signed bits, eye fits inside.
	localparam int VEC_W    = 21;
	localparam int MAG_W    = VEC_W - 1;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int SS_W     = SQ_W + 2;
	localparam int RT_STEPS = SS_W / 2;
	localparam int RT_W     = RT_STEPS;
	localparam int Q_W      = 15;
	localparam int DIV_STEPS = Q_W;
	localparam int NUM_W    = RT_W + FRAC_W + 1;
	// input reg, root steps plus its entry, divide steps plus its entry, output reg
	localparam int NORM_LAT = 1 + (RT_STEPS + 1) + (DIV_STEPS + 1) + 1;

	localparam int COS_W    = 18;
	localparam int PW_STEPS = 8;

	typedef logic signed [VEC_W-1:0] comp_t;
	typedef logic signed [15:0]      unit_t;

	typedef enum logic [2:0] {
		REG_KD_R      = 3'd0,
		REG_KD_G      = 3'd1,
		REG_KD_B      = 3'd2,
		REG_KS_R      = 3'd3,
		REG_KS_G      = 3'd4,
		REG_KS_B      = 3'd5,
		REG_SHININESS = 3'd6,
		REG_TWO_SIDED = 3'd7
	} reg_idx_t;

	// Per-item data that rides alongside the normalizers.
	typedef struct packed {
		logic             back;
		logic             kill;
		logic             pos;
		logic [COS_W-1:0] cos_d;
		logic [15:0]      inten_r;
		logic [15:0]      inten_g;
		logic [15:0]      inten_b;
	} side_t;

endpackage

@@ src/pls_norm.sv @@
// Pipelined vector normalizer: integer square root then per-component divide.
module pls_norm import pls_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  comp_t vec  [3],
	output unit_t unit [3]
);

	logic [MAG_W-1:0] mag_s1 [3];
	logic             neg_s1 [3];
	logic [SQ_W-1:0]  sq_s1  [3];

	logic [SS_W-1:0]  rt_op_q  [RT_STEPS+1];
	logic [SS_W-1:0]  rt_res_q [RT_STEPS+1];
	logic [MAG_W-1:0] rt_mag_q [RT_STEPS+1][3];
	logic             rt_neg_q [RT_STEPS+1][3];

	logic [NUM_W-1:0] dv_rem_q  [DIV_STEPS+1][3];
	logic [Q_W-1:0]   dv_quo_q  [DIV_STEPS+1][3];
	logic             dv_neg_q  [DIV_STEPS+1][3];
	logic [RT_W-1:0]  dv_len_q  [DIV_STEPS+1];
	logic             dv_zero_q [DIV_STEPS+1];

	unit_t unit_q [3];

	// Magnitudes and squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic [VEC_W-1:0] a;
				a = vec[i][VEC_W-1] ? VEC_W'(-vec[i]) : VEC_W'(vec[i]);
				mag_s1[i] <= a[MAG_W-1:0];
				neg_s1[i] <= vec[i][VEC_W-1];
				sq_s1[i]  <= SQ_W'(a[MAG_W-1:0]) * SQ_W'(a[MAG_W-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_op_q[0]  <= SS_W'(sq_s1[0]) + SS_W'(sq_s1[1]) + SS_W'(sq_s1[2]);
			rt_res_q[0] <= '0;
			rt_mag_q[0] <= mag_s1;
			rt_neg_q[0] <= neg_s1;
		end
	end

	// Square root, one result bit per stage
	for (genvar k = 0; k < RT_STEPS; k++) begin : g_rt
		localparam logic [SS_W-1:0] BIT = SS_W'(1) << (2 * (RT_STEPS - 1 - k));
		logic [SS_W-1:0] trial;
		logic            fit;
		assign trial = rt_res_q[k] + BIT;
		assign fit   = rt_op_q[k] >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rt_op_q[k+1]  <= fit ? rt_op_q[k] - trial : rt_op_q[k];
				rt_res_q[k+1] <= fit ? (rt_res_q[k] >> 1) + BIT : rt_res_q[k] >> 1;
				rt_mag_q[k+1] <= rt_mag_q[k];
				rt_neg_q[k+1] <= rt_neg_q[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem_q[0][i] <= NUM_W'({rt_mag_q[RT_STEPS][i], FRAC_W'(0)});
				dv_quo_q[0][i] <= '0;
			end
			dv_neg_q[0]  <= rt_neg_q[RT_STEPS];
			dv_len_q[0]  <= rt_res_q[RT_STEPS][RT_W-1:0];
			dv_zero_q[0] <= rt_res_q[RT_STEPS] == '0;
		end
	end

	// Restoring divide, one quotient bit per stage; quotient never exceeds 1.0
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dv
		localparam int B = DIV_STEPS - 1 - j;
		logic [NUM_W-1:0] sub;
		assign sub = NUM_W'(dv_len_q[j]) << B;
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (dv_rem_q[j][i] >= sub) begin
						dv_rem_q[j+1][i]    <= dv_rem_q[j][i] - sub;
						dv_quo_q[j+1][i]    <= dv_quo_q[j][i] | (Q_W'(1) << B);
					end else begin
						dv_rem_q[j+1][i]    <= dv_rem_q[j][i];
						dv_quo_q[j+1][i]    <= dv_quo_q[j][i];
					end
				end
				dv_neg_q[j+1]  <= dv_neg_q[j];
				dv_len_q[j+1]  <= dv_len_q[j];
				dv_zero_q[j+1] <= dv_zero_q[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic [Q_W-1:0] q;
				q = dv_zero_q[DIV_STEPS] ? '0 : dv_quo_q[DIV_STEPS][i];
				if (q > Q_W'(ONE_Q14))
					q = Q_W'(ONE_Q14);
				unit_q[i] <= dv_neg_q[DIV_STEPS][i] ? -$signed(16'(q)) : $signed(16'(q));
			end
		end
	end

	assign unit = unit_q;

endmodule

@@ src/phong_light_shader_top.sv @@
// Top level of the Phong diffuse plus specular light shader.
//
//   channel  signals                                 direction
//   in       in_valid, in_stall, ray/normal/light    hit data in
//   out      out_valid, out_stall, out_*, back_hit   shaded color out
//   cfg      cfg_wr_en, cfg_index, cfg_data           register writes
//
// One item per cycle while the output is not stalled; the depth is set by the two
// bit-per-stage normalizers (21-step root, 15-step divide) and the 8-step power.
// Reset clears valid bits and sets the config registers to defaults; payload stages are not reset.
// A stalled valid output freezes the whole pipeline; in_stall follows it directly.
module phong_light_shader_top import pls_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] ray_dir_x,
	input  logic [15:0] ray_dir_y,
	input  logic [15:0] ray_dir_z,
	input  logic [15:0] normal_x,
	input  logic [15:0] normal_y,
	input  logic [15:0] normal_z,
	input  logic [15:0] light_dir_x,
	input  logic [15:0] light_dir_y,
	input  logic [15:0] light_dir_z,
	input  logic [15:0] light_red,
	input  logic [15:0] light_green,
	input  logic [15:0] light_blue,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] out_red,
	output logic [15:0] out_green,
	output logic [15:0] out_blue,
	output logic        back_hit,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] kd_q [3];
	logic [15:0] ks_q [3];
	logic [7:0]  shininess_q;
	logic        two_sided_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kd_q        <= '{default: '0};
			ks_q        <= '{default: '0};
			shininess_q <= 8'd1;
			two_sided_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_KD_R:      kd_q[0] <= cfg_data;
				REG_KD_G:      kd_q[1] <= cfg_data;
				REG_KD_B:      kd_q[2] <= cfg_data;
				REG_KS_R:      ks_q[0] <= cfg_data;
				REG_KS_G:      ks_q[1] <= cfg_data;
				REG_KS_B:      ks_q[2] <= cfg_data;
				REG_SHININESS: shininess_q <= cfg_data[7:0];
				REG_TWO_SIDED: two_sided_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	logic signed [15:0] ray_c [3];
	logic signed [15:0] nrm_c [3];
	logic signed [15:0] lgt_c [3];
	logic [15:0]        int_c [3];
	assign ray_c = '{ray_dir_x, ray_dir_y, ray_dir_z};
	assign nrm_c = '{normal_x, normal_y, normal_z};
	assign lgt_c = '{light_dir_x, light_dir_y, light_dir_z};
	assign int_c = '{light_red, light_green, light_blue};

	// s1: eye = -ray, back-facing products
	logic               v_s1;
	logic signed [16:0] eye_s1 [3];
	logic signed [15:0] nrm_s1 [3];
	logic signed [15:0] lgt_s1 [3];
	logic [15:0]        int_s1 [3];
	logic signed [32:0] bd_s1  [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [16:0] e;
				e = -17'(ray_c[i]);
				eye_s1[i] <= e;
				bd_s1[i]  <= 33'(e) * 33'(nrm_c[i]);
			end
			nrm_s1 <= nrm_c;
			lgt_s1 <= lgt_c;
			int_s1 <= int_c;
		end
	end

	// s2: decide back hit, flip normal in two-sided mode
	logic               v_s2, back_s2, kill_s2;
	logic signed [16:0] eye_s2 [3];
	logic signed [16:0] nrm_s2 [3];
	logic signed [15:0] lgt_s2 [3];
	logic [15:0]        int_s2 [3];

	logic signed [34:0] bd_sum;
	logic               back_c;
	assign bd_sum = 35'(bd_s1[0]) + 35'(bd_s1[1]) + 35'(bd_s1[2]);
	assign back_c = bd_sum < 0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			back_s2 <= back_c;
			kill_s2 <= back_c && !two_sided_q;
			for (int i = 0; i < 3; i++)
				nrm_s2[i] <= (back_c && two_sided_q) ? -17'(nrm_s1[i]) : 17'(nrm_s1[i]);
			eye_s2 <= eye_s1;
			lgt_s2 <= lgt_s1;
			int_s2 <= int_s1;
		end
	end

	// s3: N.L products
	logic               v_s3, back_s3, kill_s3;
	logic signed [16:0] eye_s3 [3];
	logic signed [16:0] nrm_s3 [3];
	logic signed [15:0] lgt_s3 [3];
	logic [15:0]        int_s3 [3];
	logic signed [32:0] nl_s3  [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				nl_s3[i] <= 33'(nrm_s2[i]) * 33'(lgt_s2[i]);
			back_s3 <= back_s2;
			kill_s3 <= kill_s2;
			eye_s3  <= eye_s2;
			nrm_s3  <= nrm_s2;
			lgt_s3  <= lgt_s2;
			int_s3  <= int_s2;
		end
	end

	// s4: diffuse cosine
	logic               v_s4, back_s4, kill_s4, pos_s4;
	logic [COS_W-1:0]   cos_s4;
	logic signed [16:0] eye_s4 [3];
	logic signed [16:0] nrm_s4 [3];
	logic signed [15:0] lgt_s4 [3];
	logic [15:0]        int_s4 [3];

	logic signed [34:0] nl_sum;
	assign nl_sum = 35'(nl_s3[0]) + 35'(nl_s3[1]) + 35'(nl_s3[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s4  <= nl_sum > 0;
			cos_s4  <= (nl_sum > 0) ? nl_sum[FRAC_W+COS_W-1:FRAC_W] : '0;
			back_s4 <= back_s3;
			kill_s4 <= kill_s3;
			eye_s4  <= eye_s3;
			nrm_s4  <= nrm_s3;
			lgt_s4  <= lgt_s3;
			int_s4  <= int_s3;
		end
	end

	// s5: 2 * cos * N
	logic               v_s5, back_s5, kill_s5, pos_s5;
	logic [COS_W-1:0]   cos_s5;
	logic signed [16:0] eye_s5 [3];
	logic signed [15:0] lgt_s5 [3];
	logic [15:0]        int_s5 [3];
	logic signed [36:0] rp_s5  [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				rp_s5[i] <= 37'($signed({2'b00, cos_s4, 1'b0})) * 37'(nrm_s4[i]);
			pos_s5  <= pos_s4;
			cos_s5  <= cos_s4;
			back_s5 <= back_s4;
			kill_s5 <= kill_s4;
			eye_s5  <= eye_s4;
			lgt_s5  <= lgt_s4;
			int_s5  <= int_s4;
		end
	end

	// s6: reflection vector, truncated toward zero, minus L
	logic  v_s6;
	comp_t refl_s6 [3];
	comp_t eye_s6  [3];
	side_t side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic [36:0] a;
				logic [36:0] sh;
				comp_t       t;
				a  = rp_s5[i][36] ? 37'(-rp_s5[i]) : 37'(rp_s5[i]);
				sh = a >> FRAC_W;
				t  = rp_s5[i][36] ? -$signed(sh[VEC_W-1:0]) : $signed(sh[VEC_W-1:0]);
				refl_s6[i] <= t - VEC_W'(lgt_s5[i]);
				eye_s6[i]  <= VEC_W'(eye_s5[i]);
			end
			side_s6.back    <= back_s5;
			side_s6.kill    <= kill_s5;
			side_s6.pos     <= pos_s5;
			side_s6.cos_d   <= cos_s5;
			side_s6.inten_r <= int_s5[0];
			side_s6.inten_g <= int_s5[1];
			side_s6.inten_b <= int_s5[2];
		end
	end

	unit_t rhat [3];
	unit_t ehat [3];

	pls_norm u_norm_refl (
		.clk  (clk),
		.en   (en),
		.vec  (refl_s6),
		.unit (rhat)
	);

	pls_norm u_norm_eye (
		.clk  (clk),
		.en   (en),
		.vec  (eye_s6),
		.unit (ehat)
	);

	// Side data and valid follow the normalizers
	side_t side_q [NORM_LAT];
	logic  sv_q   [NORM_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_q <= '{default: 1'b0};
		end else if (en) begin
			sv_q[0] <= v_s6;
			for (int k = 1; k < NORM_LAT; k++)
				sv_q[k] <= sv_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s6;
			for (int k = 1; k < NORM_LAT; k++)
				side_q[k] <= side_q[k-1];
		end
	end

	// s7: R.E products
	logic               v_s7;
	side_t              side_s7;
	logic signed [31:0] cp_s7 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (en)
			v_s7 <= sv_q[NORM_LAT-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				cp_s7[i] <= 32'(rhat[i]) * 32'(ehat[i]);
			side_s7 <= side_q[NORM_LAT-1];
		end
	end

	// s8: clamped specular cosine, start of the power chain
	logic signed [33:0] cs_sum;
	logic [19:0]        cs_sh;
	assign cs_sum = 34'(cp_s7[0]) + 34'(cp_s7[1]) + 34'(cp_s7[2]);
	assign cs_sh  = cs_sum[FRAC_W+19:FRAC_W];

	logic [Q_W-1:0] pw_q   [PW_STEPS+1];
	logic [Q_W-1:0] base_q [PW_STEPS+1];
	side_t          pside_q [PW_STEPS+1];
	logic           pv_q   [PW_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= '{default: 1'b0};
		end else if (en) begin
			pv_q[0] <= v_s7;
			for (int k = 0; k < PW_STEPS; k++)
				pv_q[k+1] <= pv_q[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (cs_sum <= 0)
				base_q[0] <= '0;
			else if (cs_sh > 20'(ONE_Q14))
				base_q[0] <= Q_W'(ONE_Q14);
			else
				base_q[0] <= cs_sh[Q_W-1:0];
			pw_q[0]    <= Q_W'(ONE_Q14);
			pside_q[0] <= side_s7;
		end
	end

	// Power by repeated squaring, one exponent bit per stage
	for (genvar k = 0; k < PW_STEPS; k++) begin : g_pw
		logic [2*Q_W-1:0] pm;
		logic [2*Q_W-1:0] bm;
		assign pm = (2*Q_W)'(pw_q[k]) * (2*Q_W)'(base_q[k]);
		assign bm = (2*Q_W)'(base_q[k]) * (2*Q_W)'(base_q[k]);
		always_ff @(posedge clk) begin
			if (en) begin
				pw_q[k+1]    <= shininess_q[k] ? pm[FRAC_W+Q_W-1:FRAC_W] : pw_q[k];
				base_q[k+1]  <= bm[FRAC_W+Q_W-1:FRAC_W];
				pside_q[k+1] <= pside_q[k];
			end
		end
	end

	// s9: cosine times intensity
	side_t        ps;
	logic [Q_W-1:0] pw_eff;
	logic [15:0]  int_p [3];
	assign ps     = pside_q[PW_STEPS];
	assign pw_eff = ps.pos ? pw_q[PW_STEPS] : '0;
	assign int_p  = '{ps.inten_r, ps.inten_g, ps.inten_b};

	logic        v_s9, back_s9, kill_s9;
	logic [33:0] dm_s9 [3];
	logic [30:0] sm_s9 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s9 <= 1'b0;
		else if (en)
			v_s9 <= pv_q[PW_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dm_s9[i] <= 34'(ps.cos_d) * 34'(int_p[i]);
				sm_s9[i] <= 31'(pw_eff) * 31'(int_p[i]);
			end
			back_s9 <= ps.back;
			kill_s9 <= ps.kill;
		end
	end

	// s10: times material color
	logic        v_s10, back_s10, kill_s10;
	logic [49:0] dm_s10 [3];
	logic [46:0] sm_s10 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s10 <= 1'b0;
		else if (en)
			v_s10 <= v_s9;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dm_s10[i] <= 50'(dm_s9[i]) * 50'(kd_q[i]);
				sm_s10[i] <= 47'(sm_s9[i]) * 47'(ks_q[i]);
			end
			back_s10 <= back_s9;
			kill_s10 <= kill_s9;
		end
	end

	// Output register: add, saturate, zero one-sided back hits
	logic [15:0] col_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= v_s10;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic [24:0] t;
				t = 25'(dm_s10[i][49:COL_SHIFT]) + 25'(sm_s10[i][46:COL_SHIFT]);
				if (kill_s10)
					col_q[i] <= '0;
				else if (t > 25'hFFFF)
					col_q[i] <= 16'hFFFF;
				else
					col_q[i] <= t[15:0];
			end
			back_hit <= back_s10;
		end
	end

	assign out_red   = col_q[0];
	assign out_green = col_q[1];
	assign out_blue  = col_q[2];

	a_one_sided_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && back_hit && !two_sided_q |->
			out_red == 16'd0 && out_green == 16'd0 && out_blue == 16'd0)
		else $error("one-sided back hit gave nonzero color");

	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		pv_q[1] |-> base_q[1] <= Q_W'(ONE_Q14) && pw_q[1] <= Q_W'(ONE_Q14))
		else $error("specular power chain left unit range");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> $past(rhat[0]) <= 16'sd16384 && $past(rhat[0]) >= -16'sd16384)
		else $error("normalized reflection out of range");

	a_shine_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pv_q[PW_STEPS] && shininess_q == 8'd0 |-> pw_q[PW_STEPS] == Q_W'(ONE_Q14))
		else $error("zero exponent did not give one");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s10) && $stable(pv_q[PW_STEPS]))
		else $error("pipeline moved while output was blocked");

endmodule
